/* rtl/clte_pkg.sv */
// Shared types and constants for the compacting list table engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
package clte_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CNT_OUT_W    = 6;

  // Flipping the sign bit turns signed order into unsigned order.
  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_DEL_MIN = 3'd1,
    CMD_DEL_AT  = 3'd2,
    CMD_DEL_VAL = 3'd3,
    CMD_DEL_RNG = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Micro-operations issued by the controller to the datapath.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,      // capture input transfer, clear write pointer, idx to 0 or position
    OP_APPEND,    // write at count, count up
    OP_RD_IDX,    // read entry at idx
    OP_RD_NEXT,   // read entry at idx + 1
    OP_RD_LAST,   // read entry at count - 1
    OP_MIN_EVAL,  // fold read data into running min, idx up
    OP_IDX_CLR,
    OP_IDX_INC,
    OP_MOVE,      // write read data at idx, count down
    OP_SHIFT,     // write read data at idx, idx up
    OP_CNT_DEC,
    OP_FILTER,    // keep read data at wr unless in bounds, idx up
    OP_CNT_SET,   // count takes the write pointer
    OP_RESULT     // load output register
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e res_status;
    logic    res_min;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             pos_bad;
    logic             idx_end;
    logic             at_last;
    logic             eq_min;
    logic             out_free;
  } dp_stat_t;

endpackage

/* rtl/clte_if.sv */
// Valid/ready channel interfaces for input items and results.
// Depends on clte_pkg for field widths.
interface clte_in_if import clte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] data_value;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] range_low;
  logic signed [DATA_W-1:0] range_high;

  modport source (output valid, command, data_value, position, range_low, range_high,
                  input ready);
  modport sink   (input valid, command, data_value, position, range_low, range_high,
                  output ready);
endinterface

interface clte_out_if import clte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] removed_min;
  logic [CNT_OUT_W-1:0]     entry_count;

  modport source (output valid, status, removed_min, entry_count, input ready);
  modport sink   (input valid, status, removed_min, entry_count, output ready);
endinterface

/* rtl/clte_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clte_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/clte_dp.sv */
// Datapath: entry RAM, count and pointers, key compare, output register.
// Depends on clte_pkg and clte_ram; driven by clte_ctrl through dp_cmd_t.
module clte_dp import clte_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] range_low_i,
  input  logic signed [DATA_W-1:0] range_high_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] removed_min_o,
  output logic [CNT_OUT_W-1:0]     entry_count_o
);

  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        wr_q, wr_d;
  logic [DATA_W-1:0]    lo_q, lo_d;
  logic [DATA_W-1:0]    hi_q, hi_d;
  logic [DATA_W-1:0]    min_q, min_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 out_valid_q, out_valid_d;
  logic [STAT_W-1:0]    out_status_q, out_status_d;
  logic [DATA_W-1:0]    out_min_q, out_min_d;
  logic [CNT_OUT_W-1:0] out_cnt_q, out_cnt_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]     idx_nx, cnt_dec;
  logic [DATA_W-1:0] key_data;
  logic              in_bounds;

  assign idx_nx    = idx_q + 1'b1;
  assign cnt_dec   = cnt_q - 1'b1;
  assign key_data  = data_value_i ^ SIGN_FLIP;
  assign in_bounds = (ram_rdata >= lo_q) && (ram_rdata <= hi_q);

  clte_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    wr_d         = wr_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    min_d        = min_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_min_d    = out_min_q;
    out_cnt_d    = out_cnt_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = idx_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_q[AW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (cmd_i.op)
      OP_LOAD: begin
        cmd_d = command_i;
        pos_d = position_i;
        min_d = '1;
        wr_d  = '0;
        idx_d = (command_i == CMD_DEL_AT) ? CW'(position_i) : '0;
        if (command_i == CMD_DEL_RNG) begin
          lo_d = range_low_i ^ SIGN_FLIP;
          hi_d = range_high_i ^ SIGN_FLIP;
        end else begin
          lo_d = key_data;
          hi_d = key_data;
        end
      end
      OP_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = lo_q;
        cnt_d     = cnt_q + 1'b1;
      end
      OP_RD_IDX: begin
        ram_re = 1'b1;
      end
      OP_RD_NEXT: begin
        ram_re    = 1'b1;
        ram_raddr = idx_nx[AW-1:0];
      end
      OP_RD_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_dec[AW-1:0];
      end
      OP_MIN_EVAL: begin
        if (ram_rdata < min_q) begin
          min_d = ram_rdata;
        end
        idx_d = idx_nx;
      end
      OP_IDX_CLR: idx_d = '0;
      OP_IDX_INC: idx_d = idx_nx;
      OP_MOVE: begin
        ram_we = 1'b1;
        cnt_d  = cnt_dec;
      end
      OP_SHIFT: begin
        ram_we = 1'b1;
        idx_d  = idx_nx;
      end
      OP_CNT_DEC: cnt_d = cnt_dec;
      OP_FILTER: begin
        if (!in_bounds) begin
          ram_we    = 1'b1;
          ram_waddr = wr_q[AW-1:0];
          wr_d      = wr_q + 1'b1;
        end
        idx_d = idx_nx;
      end
      OP_CNT_SET: cnt_d = wr_q;
      OP_RESULT: begin
        out_valid_d  = 1'b1;
        out_status_d = cmd_i.res_status;
        out_min_d    = cmd_i.res_min ? (min_q ^ SIGN_FLIP) : '0;
        out_cnt_d    = CNT_OUT_W'(cnt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cmd_q       <= cmd_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      wr_q        <= wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    min_q        <= min_d;
    pos_q        <= pos_d;
    out_status_q <= out_status_d;
    out_min_q    <= out_min_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.full     = (cnt_q == CW'(CAPACITY));
  assign stat_o.pos_bad  = (PW'(pos_q) >= PW'(cnt_q));
  assign stat_o.idx_end  = (idx_q >= cnt_q);
  assign stat_o.at_last  = (({1'b0, idx_q} + 1'b1) >= {1'b0, cnt_q});
  assign stat_o.eq_min   = (ram_rdata == min_q);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign removed_min_o = out_min_q;
  assign entry_count_o = out_cnt_q;

  // Count never passes capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Append is only issued with room left.
  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_APPEND |-> cnt_q != CW'(CAPACITY))
    else $error("append on full list");

  // Moving the last entry down needs a non-empty list.
  a_move_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_MOVE |-> cnt_q != '0)
    else $error("move with empty list");

  // A result never overwrites one that has not been taken.
  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_RESULT |-> (!out_valid_q || out_ready_i))
    else $error("result register overrun");

  // Filter write pointer never runs ahead of the read pointer.
  a_filter_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_FILTER |-> wr_q <= idx_q)
    else $error("filter write pointer ahead of read pointer");

endmodule

/* rtl/clte_ctrl.sv */
// Controller FSM: sequences one command at a time over the datapath.
// Depends on clte_pkg; talks to clte_dp through dp_cmd_t and dp_stat_t.
module clte_ctrl import clte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SR_RD,
    S_SR_EV,
    S_RM_RD,
    S_RM_EV,
    S_RM_MOVE,
    S_AT_CHK,
    S_AT_MV,
    S_F_RD,
    S_F_EV,
    S_DONE
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;
  logic    rmin_q, rmin_d;
  dp_op_e  op;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    rmin_d  = rmin_q;
    op      = OP_NOP;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        res_d   = ST_OK;
        rmin_d  = 1'b0;
        state_d = S_DONE;
        unique case (stat_i.cmd) inside
          CMD_APPEND: begin
            if (stat_i.full) begin
              res_d = ST_FULL;
            end else begin
              op = OP_APPEND;
            end
          end
          CMD_DEL_MIN: begin
            if (stat_i.empty) begin
              res_d = ST_EMPTY;
            end else begin
              rmin_d  = 1'b1;
              state_d = S_SR_RD;
            end
          end
          CMD_DEL_AT: begin
            if (stat_i.empty) begin
              res_d = ST_EMPTY;
            end else if (stat_i.pos_bad) begin
              res_d = ST_BADPOS;
            end else begin
              state_d = S_AT_CHK;
            end
          end
          CMD_DEL_VAL, CMD_DEL_RNG: begin
            if (stat_i.empty) begin
              res_d = ST_EMPTY;
            end else begin
              state_d = S_F_RD;
            end
          end
          default: ;
        endcase
      end
      // min search pass
      S_SR_RD: begin
        if (stat_i.idx_end) begin
          op      = OP_IDX_CLR;
          state_d = S_RM_RD;
        end else begin
          op      = OP_RD_IDX;
          state_d = S_SR_EV;
        end
      end
      S_SR_EV: begin
        op      = OP_MIN_EVAL;
        state_d = S_SR_RD;
      end
      // removal pass: last entry fills a matching slot, slot is rechecked
      S_RM_RD: begin
        if (stat_i.idx_end) begin
          state_d = S_DONE;
        end else begin
          op      = OP_RD_IDX;
          state_d = S_RM_EV;
        end
      end
      S_RM_EV: begin
        if (stat_i.eq_min) begin
          op      = OP_RD_LAST;
          state_d = S_RM_MOVE;
        end else begin
          op      = OP_IDX_INC;
          state_d = S_RM_RD;
        end
      end
      S_RM_MOVE: begin
        op      = OP_MOVE;
        state_d = S_RM_RD;
      end
      // delete at position: shift tail down by one
      S_AT_CHK: begin
        if (stat_i.at_last) begin
          op      = OP_CNT_DEC;
          state_d = S_DONE;
        end else begin
          op      = OP_RD_NEXT;
          state_d = S_AT_MV;
        end
      end
      S_AT_MV: begin
        op      = OP_SHIFT;
        state_d = S_AT_CHK;
      end
      // order-keeping filter
      S_F_RD: begin
        if (stat_i.idx_end) begin
          op      = OP_CNT_SET;
          state_d = S_DONE;
        end else begin
          op      = OP_RD_IDX;
          state_d = S_F_EV;
        end
      end
      S_F_EV: begin
        op      = OP_FILTER;
        state_d = S_F_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          op      = OP_RESULT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_OK;
      rmin_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      rmin_q  <= rmin_d;
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign cmd_o.op         = op;
  assign cmd_o.res_status = res_q;
  assign cmd_o.res_min    = rmin_q;

endmodule

/* rtl/compacting_list_table_engine.sv */
// Compacting list table engine: bounded list of signed values with a count.
// One item at a time: every entry step is a RAM read then a compare or write through
// the single read port, so the next item is taken once the current one has its result.
// Reset clears count and control; entry RAM is not cleared (entries above count unused).
module compacting_list_table_engine import clte_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  clte_in_if.sink   in_i,
  clte_out_if.source out_o
);

  // Controller/datapath link.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;

  // The input side is ready whenever the controller sits idle. A finished
  // result waits in the datapath output register, so a new transfer can be
  // taken before the previous result has been consumed; the controller only
  // stalls at the end of that next item if the register is still occupied.
  assign in_i.ready = in_ready;

  clte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath holds the entry RAM (keys stored with the sign bit flipped so
  // that an unsigned compare gives signed order), the count, the read and
  // write pointers, the running minimum and the result register.
  clte_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .command_i     (in_i.command),
    .data_value_i  (in_i.data_value),
    .position_i    (in_i.position),
    .range_low_i   (in_i.range_low),
    .range_high_i  (in_i.range_high),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .status_o      (out_o.status),
    .removed_min_o (out_o.removed_min),
    .entry_count_o (out_o.entry_count)
  );

endmodule
